### hdl/sliding_window_percentile_unit_macros.svh
// Assertion macros shared by the sliding window percentile unit.
`ifndef SLIDING_WINDOW_PERCENTILE_UNIT_MACROS_SVH
`define SLIDING_WINDOW_PERCENTILE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every clock edge outside reset.
`define SWPU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define SWPU_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWPU_ASSERT(name, prop, msg)
`define SWPU_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

### hdl/swpu_pkg.sv
// Shared types and constants of the sliding window percentile unit.
`default_nettype none
package swpu_pkg;

  // Percentile scale: hundredths of a percent.
  localparam int FULL_SCALE      = 10000;
  localparam int PCT_BITS        = 14;
  localparam int PCT_RESET       = 9900;
  localparam int LATENCY_BITS    = 32;
  localparam int RESULT_BITS     = 32;
  localparam int OP_BITS         = 2;
  localparam int CAPACITY_DEF    = 256;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int TREE_GROUP      = 16;

  // Item operation codes.
  typedef enum logic [OP_BITS-1:0] {
    OP_RECORD = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  // Command broadcast to every cell of the sorted chain.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DELETE,
    CELL_INSERT
  } cell_cmd_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DELETE,
    ST_INSERT,
    ST_PRODUCT,
    ST_REDUCE,
    ST_GATHER,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

### hdl/swpu_ram.sv
// Generic single write port RAM with a registered read port.
`default_nettype none
module swpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hdl/swpu_cell.sv
// One cell of the sorted sample chain, with its rank selection.
`default_nettype none
module swpu_cell #(
  parameter int SAMPLE_BITS = swpu_pkg::SAMPLE_BITS_DEF,
  parameter int PN_BITS     = 23,
  parameter int INDEX       = 0
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire swpu_pkg::cell_cmd_t     cmd,
  input  wire logic [SAMPLE_BITS-1:0]  key,
  input  wire logic [PN_BITS-1:0]      pn,
  input  wire logic [SAMPLE_BITS-1:0]  left_value,
  input  wire logic                    left_valid,
  input  wire logic                    left_gt,
  input  wire logic [SAMPLE_BITS-1:0]  right_value,
  input  wire logic                    right_valid,
  output logic [SAMPLE_BITS-1:0]       value,
  output logic                         valid,
  output logic                         gt,
  output logic [SAMPLE_BITS-1:0]       pick
);
  import swpu_pkg::*;

  // Bounds of p*n for which this cell holds the nearest-rank sample.
  localparam logic [PN_BITS-1:0] RANK_LO = PN_BITS'(longint'(INDEX) * FULL_SCALE);
  localparam logic [PN_BITS-1:0] RANK_HI = PN_BITS'(longint'(INDEX + 1) * FULL_SCALE);

  logic [SAMPLE_BITS-1:0] value_next;
  logic                   valid_next;
  logic                   ge_key;
  logic                   sel;

  // An empty cell counts as larger than any key.
  assign gt     = !valid || (value > key);
  assign ge_key = valid && (value >= key);

  // Delete shifts the upper part down; insert shifts it up and drops the key in.
  always_comb begin
    value_next = value;
    valid_next = valid;
    case (cmd)
      CELL_CLEAR: begin
        valid_next = 1'b0;
      end
      CELL_DELETE: begin
        if (ge_key) begin
          value_next = right_value;
          valid_next = right_valid;
        end
      end
      CELL_INSERT: begin
        if (gt) begin
          if (left_gt) begin
            value_next = left_value;
            valid_next = left_valid;
          end else begin
            value_next = key;
            valid_next = 1'b1;
          end
        end
      end
      default: begin
        value_next = value;
        valid_next = valid;
      end
    endcase
  end

  // Cell storage: only the valid flag is cleared by reset.
  always_ff @(posedge clk) begin
    value <= value_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // The first cell also covers a rank that rounds to zero.
  assign sel  = valid && (pn <= RANK_HI) && ((INDEX == 0) || (pn > RANK_LO));
  assign pick = sel ? value : '0;

endmodule
`default_nettype wire

### hdl/swpu_or_tree.sv
// Two-stage registered OR tree that gathers the one selected cell value.
`default_nettype none
module swpu_or_tree #(
  parameter int WIDTH = 32,
  parameter int COUNT = 256,
  parameter int GROUP = swpu_pkg::TREE_GROUP
) (
  input  wire logic                        clk,
  input  wire logic [COUNT-1:0][WIDTH-1:0] leaf,
  output logic      [WIDTH-1:0]            root
);

  localparam int NGROUPS = (COUNT + GROUP - 1) / GROUP;

  logic [NGROUPS-1:0][WIDTH-1:0] group_or;
  logic [NGROUPS-1:0][WIDTH-1:0] group_reg;
  logic [WIDTH-1:0]              root_or;

  // First level: OR within each group of cells.
  always_comb begin
    group_or = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      for (int i = 0; i < GROUP; i++) begin
        if (g * GROUP + i < COUNT) begin
          group_or[g] = group_or[g] | leaf[g * GROUP + i];
        end
      end
    end
  end

  // Second level: OR across the registered groups.
  always_comb begin
    root_or = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      root_or = root_or | group_reg[g];
    end
  end

  always_ff @(posedge clk) begin
    group_reg <= group_or;
    root      <= root_or;
  end

endmodule
`default_nettype wire

### hdl/sliding_window_percentile_unit.sv
// A query or clear runs the read, product, reduce, gather and done steps; a record adds an
// insert step, and a record into a full window needs an extra delete step before it.
// A new item is taken only in the idle state, after the last result is loaded into the
// output register; a result held by the receiver stalls the sequencer in its last step.
// Reset (synchronous, active high) empties the window, zeroes the pointer and count,
// and sets the percentile to 99.00; no clearing pass is needed.
`default_nettype none
`include "sliding_window_percentile_unit_macros.svh"
module sliding_window_percentile_unit #(
  parameter int CAPACITY    = swpu_pkg::CAPACITY_DEF,
  parameter int SAMPLE_BITS = swpu_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  // Configuration: percentile in hundredths of a percent.
  input  wire logic                                     cfg_valid,
  output logic                                          cfg_ready,
  input  wire logic [swpu_pkg::PCT_BITS-1:0]            cfg_data,
  // Input items.
  input  wire logic                                     s_tvalid,
  output logic                                          s_tready,
  input  wire logic [swpu_pkg::LATENCY_BITS-1:0]        s_tdata,  // [31:0] latency_us
  input  wire logic [swpu_pkg::OP_BITS-1:0]             s_tuser,  // [1:0] op
  // Result items.
  output logic                                          m_tvalid,
  input  wire logic                                     m_tready,
  // [31:0] percentile_value, then window_count, zero padded to whole bytes
  output logic [((swpu_pkg::RESULT_BITS + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata
);
  import swpu_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PN_W  = PCT_BITS + CNT_W;
  localparam int OUT_W = ((RESULT_BITS + CNT_W + 7) / 8) * 8;

  state_t                   state;
  state_t                   state_next;
  cell_cmd_t                cmd;
  op_t                      op;
  logic [SAMPLE_BITS-1:0]   sample;
  logic [SAMPLE_BITS-1:0]   sample_in;
  logic [SAMPLE_BITS-1:0]   key;
  logic [SAMPLE_BITS-1:0]   old_sample;
  logic [PTR_W-1:0]         wp;
  logic [CNT_W-1:0]         count;
  logic [PCT_BITS-1:0]      pct;
  logic [PCT_BITS-1:0]      pct_clamped;
  logic [PN_W-1:0]          pn;
  logic                     full;
  logic                     ram_re;
  logic                     ram_we;
  logic                     accept;
  logic                     load_out;
  logic [RESULT_BITS-1:0]   percentile_value;
  logic [CNT_W-1:0]         window_count;
  logic [SAMPLE_BITS-1:0]   tree_root;
  logic [SAMPLE_BITS+31:0]  root_ext;

  logic [CAPACITY-1:0][SAMPLE_BITS-1:0] cell_value;
  logic [CAPACITY-1:0]                  cell_valid;
  logic [CAPACITY-1:0]                  cell_gt;
  logic [CAPACITY-1:0][SAMPLE_BITS-1:0] cell_pick;

  assign full      = (count == CNT_W'(CAPACITY));
  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;

  // Saturate an incoming sample to the stored width.
  always_comb begin
    if ((s_tdata >> SAMPLE_BITS) != '0) begin
      sample_in = '1;
    end else begin
      sample_in = SAMPLE_BITS'(s_tdata);
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pct <= PCT_BITS'(PCT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      pct <= cfg_data;
    end
  end

  assign pct_clamped = (pct > PCT_BITS'(FULL_SCALE)) ? PCT_BITS'(FULL_SCALE) : pct;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and chain commands.
  always_comb begin
    state_next = state;
    cmd        = CELL_HOLD;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        ram_re = 1'b1;
        case (op)
          OP_RECORD: state_next = full ? ST_DELETE : ST_INSERT;
          OP_CLEAR: begin
            cmd        = CELL_CLEAR;
            state_next = ST_PRODUCT;
          end
          default: state_next = ST_PRODUCT;
        endcase
      end
      ST_DELETE: begin
        cmd        = CELL_DELETE;
        state_next = ST_INSERT;
      end
      ST_INSERT: begin
        cmd        = CELL_INSERT;
        ram_we     = 1'b1;
        state_next = ST_PRODUCT;
      end
      ST_PRODUCT: state_next = ST_REDUCE;
      ST_REDUCE:  state_next = ST_GATHER;
      ST_GATHER:  state_next = ST_DONE;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Item registers, ring pointer, fill count and rank product.
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= op_t'(s_tuser);
      sample <= sample_in;
    end
    if (state == ST_PRODUCT) begin
      pn <= PN_W'(pct_clamped) * PN_W'(count);
    end
    if (rst) begin
      wp    <= '0;
      count <= '0;
    end else if (state == ST_READ && op == OP_CLEAR) begin
      wp    <= '0;
      count <= '0;
    end else if (state == ST_INSERT) begin
      wp <= (wp == PTR_W'(CAPACITY - 1)) ? '0 : wp + 1'b1;
      if (!full) begin
        count <= count + 1'b1;
      end
    end
  end

  // Ring of samples in arrival order, read back to find the oldest.
  swpu_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(CAPACITY)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp),
    .wdata(sample),
    .re   (ram_re),
    .raddr(wp),
    .rdata(old_sample)
  );

  assign key = (state == ST_DELETE) ? old_sample : sample;

  // Sorted chain of cells, smallest sample in cell 0.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] lv;
    logic                   lval;
    logic                   lgt;
    logic [SAMPLE_BITS-1:0] rv;
    logic                   rval;

    if (i == 0) begin : g_first
      assign lv   = '0;
      assign lval = 1'b0;
      assign lgt  = 1'b0;
    end else begin : g_mid
      assign lv   = cell_value[i-1];
      assign lval = cell_valid[i-1];
      assign lgt  = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rv   = '0;
      assign rval = 1'b0;
    end else begin : g_inner
      assign rv   = cell_value[i+1];
      assign rval = cell_valid[i+1];
    end

    swpu_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .PN_BITS    (PN_W),
      .INDEX      (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .key        (key),
      .pn         (pn),
      .left_value (lv),
      .left_valid (lval),
      .left_gt    (lgt),
      .right_value(rv),
      .right_valid(rval),
      .value      (cell_value[i]),
      .valid      (cell_valid[i]),
      .gt         (cell_gt[i]),
      .pick       (cell_pick[i])
    );
  end

  // Gather the selected cell value.
  swpu_or_tree #(
    .WIDTH(SAMPLE_BITS),
    .COUNT(CAPACITY),
    .GROUP(TREE_GROUP)
  ) u_tree (
    .clk (clk),
    .leaf(cell_pick),
    .root(tree_root)
  );

  // Saturate the result to the output width.
  assign root_ext = {32'b0, tree_root};

  // Output register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      percentile_value <= ((root_ext >> 32) != '0) ? '1 : RESULT_BITS'(tree_root);
      window_count     <= count;
    end
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = OUT_W'({window_count, percentile_value});

  // The fill count never passes the capacity.
  `SWPU_ASSERT(a_count_range, count <= CNT_W'(CAPACITY), "fill count above capacity")
  // Between items the valid cells match the fill count.
  `SWPU_ASSERT(a_valid_count, (state == ST_IDLE) |-> ($countones(cell_valid) == count), "cell valid bits disagree with fill count")
  // Until the window is full the write pointer equals the fill count.
  `SWPU_ASSERT(a_ptr_count, (count < CNT_W'(CAPACITY)) |-> (count == CNT_W'(wp)), "write pointer out of step with fill count")
  // A result appears only after the last sequencer step.
  `SWPU_ASSERT(a_result_source, $rose(m_tvalid) |-> $past(state == ST_DONE), "result shown outside the final step")

endmodule
`default_nettype wire

### tb/sliding_window_percentile_unit_test.sv
// Self-checking testbench for the sliding window percentile unit, with directed and random items.
`default_nettype none
module sliding_window_percentile_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import swpu_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 10;
  localparam int WINDOW_DEPTH = CAPACITY_DEF;
  localparam int COUNT_BITS   = $clog2(WINDOW_DEPTH + 1);
  localparam int RESULT_W     = ((RESULT_BITS + COUNT_BITS + 7) / 8) * 8;
  localparam int CYCLE_LIMIT  = 500000;
  // Margin waited after the last result, past what the block needs for one item.
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 6;
  localparam int DIRECTED_ROWS = 25;

  // Operation code outside the defined set; the block treats it as a query.
  localparam logic [OP_BITS-1:0] OP_SPARE = 2'd3;
  // Largest register code, well above the full scale.
  localparam logic [PCT_BITS-1:0] PCT_ABOVE = '1;
  localparam logic [LATENCY_BITS-1:0] LAT_MAX = '1;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [PCT_BITS-1:0]     cfg_data = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [LATENCY_BITS-1:0] s_tdata = '0;  // [31:0] latency_us
  logic [OP_BITS-1:0]      s_tuser = '0;  // [1:0] op
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [RESULT_W-1:0]     m_tdata;       // [31:0] percentile_value, [40:32] window_count

  sliding_window_percentile_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  typedef struct packed {
    logic [RESULT_BITS-1:0] value;
    logic [COUNT_BITS-1:0]  count;
  } window_result_t;

  typedef enum bit {ROW_ITEM, ROW_PCT} row_kind_t;

  // One directed row: an item or a percentile write (data holds the setting).
  typedef struct packed {
    row_kind_t               kind;
    logic [OP_BITS-1:0]      op;
    logic [LATENCY_BITS-1:0] data;
    bit                      typed;
    logic [RESULT_BITS-1:0]  want_value;
    logic [COUNT_BITS-1:0]   want_count;
  } stim_row_t;

  // Directed table. Expected results are typed in only where obvious.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_ITEM, OP_QUERY,  32'h0,        1'b1, 32'h0,   9'd0},
    '{ROW_ITEM, OP_CLEAR,  32'h0,        1'b1, 32'h0,   9'd0},
    '{ROW_ITEM, OP_SPARE,  LAT_MAX,      1'b1, 32'h0,   9'd0},
    '{ROW_ITEM, OP_RECORD, LAT_MAX,      1'b1, LAT_MAX, 9'd1},
    '{ROW_ITEM, OP_RECORD, 32'h0,        1'b1, LAT_MAX, 9'd2},
    '{ROW_ITEM, OP_QUERY,  32'h0,        1'b1, LAT_MAX, 9'd2},
    '{ROW_ITEM, OP_SPARE,  32'h0,        1'b1, LAT_MAX, 9'd2},
    '{ROW_ITEM, OP_CLEAR,  LAT_MAX,      1'b1, 32'h0,   9'd0},
    '{ROW_ITEM, OP_RECORD, 32'h0,        1'b1, 32'h0,   9'd1},
    '{ROW_ITEM, OP_RECORD, 32'd12345,    1'b0, 32'h0,   9'd0},
    '{ROW_ITEM, OP_RECORD, 32'hAAAAAAAA, 1'b0, 32'h0,   9'd0},
    '{ROW_ITEM, OP_RECORD, 32'h55555555, 1'b0, 32'h0,   9'd0},
    '{ROW_ITEM, OP_RECORD, 32'h1,        1'b0, 32'h0,   9'd0},
    '{ROW_ITEM, OP_RECORD, 32'h80000000, 1'b0, 32'h0,   9'd0},
    '{ROW_ITEM, OP_RECORD, 32'h7FFFFFFF, 1'b0, 32'h0,   9'd0},
    '{ROW_ITEM, OP_RECORD, 32'd12345,    1'b0, 32'h0,   9'd0},
    '{ROW_ITEM, OP_QUERY,  LAT_MAX,      1'b0, 32'h0,   9'd0},
    '{ROW_PCT,  OP_QUERY,  32'd0,        1'b0, 32'h0,   9'd0},
    '{ROW_ITEM, OP_QUERY,  32'h0,        1'b1, 32'h0,   9'd8},
    '{ROW_PCT,  OP_QUERY,  FULL_SCALE,   1'b0, 32'h0,   9'd0},
    '{ROW_ITEM, OP_QUERY,  32'h0,        1'b1, 32'hAAAAAAAA, 9'd8},
    '{ROW_PCT,  OP_QUERY,  PCT_ABOVE,    1'b0, 32'h0,   9'd0},
    '{ROW_ITEM, OP_QUERY,  32'h0,        1'b1, 32'hAAAAAAAA, 9'd8},
    '{ROW_PCT,  OP_QUERY,  32'd1,        1'b0, 32'h0,   9'd0},
    '{ROW_ITEM, OP_RECORD, LAT_MAX,      1'b0, 32'h0,   9'd0}
  };

  // Shadow of the window and of the percentile register.
  logic [LATENCY_BITS-1:0] window_samples [WINDOW_DEPTH];
  int unsigned             ring_ptr = 0;
  int unsigned             samples_held = 0;
  int unsigned             pct_setting = PCT_RESET;
  window_result_t          expected_percentiles [$];

  int          mismatches = 0;
  int          items_sent = 0;
  int          clears_sent = 0;
  int          results_checked = 0;
  int          full_window_results = 0;
  int unsigned cycle_count = 0;
  bit          hold_active = 1'b0;

  // Apply one item to the shadow window and return the percentile it yields.
  function automatic window_result_t predict_percentile(logic [OP_BITS-1:0] op,
                                                        logic [LATENCY_BITS-1:0] sample);
    logic [LATENCY_BITS-1:0] ordered [WINDOW_DEPTH];
    logic [LATENCY_BITS-1:0] v;
    window_result_t          r;
    int unsigned             p;
    int unsigned             rank;
    int                      j;
    if (op == OP_RECORD) begin
      window_samples[ring_ptr] = sample;
      ring_ptr = (ring_ptr + 1) % WINDOW_DEPTH;
      if (samples_held < WINDOW_DEPTH) samples_held++;
    end else if (op == OP_CLEAR) begin
      ring_ptr = 0;
      samples_held = 0;
    end
    r.count = COUNT_BITS'(samples_held);
    r.value = '0;
    if (samples_held != 0) begin
      p = (pct_setting > FULL_SCALE) ? FULL_SCALE : pct_setting;
      rank = (p * samples_held + FULL_SCALE - 1) / FULL_SCALE;
      if (rank < 1) rank = 1;
      if (rank > samples_held) rank = samples_held;
      // Insertion sort of the held samples, then pick by rank.
      for (int i = 0; i < samples_held; i++) begin
        v = window_samples[i];
        j = i;
        while (j > 0 && ordered[j-1] > v) begin
          ordered[j] = ordered[j-1];
          j--;
        end
        ordered[j] = v;
      end
      r.value = ordered[rank-1];
    end
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sample mix: full range, small values with many repeats, and the extremes.
  function automatic logic [LATENCY_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $urandom_range(0, 15);
      7:          return '0;
      8:          return LAT_MAX;
      default:    return LAT_MAX - $urandom_range(0, 255);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [RESULT_BITS-1:0] want,
                                 logic [RESULT_BITS-1:0] got);
    mismatches++;
    $display("[%0t] result %0d: %s expected 0x%0h got 0x%0h",
             $time, results_checked, what, want, got);
  endtask

  // Offer one item until it is taken, then record its expected result.
  task automatic send_item(logic [OP_BITS-1:0] op, logic [LATENCY_BITS-1:0] sample,
                           bit typed, window_result_t want);
    window_result_t predicted;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= sample;
    do @(posedge clk); while (!s_tready);
    predicted = predict_percentile(op, sample);
    expected_percentiles.push_back(typed ? want : predicted);
    items_sent++;
    if (op == OP_CLEAR) clears_sent++;
  endtask

  task automatic idle_sender(int unsigned cycles);
    if (cycles != 0) begin
      s_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stop offering items and wait until every result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_percentiles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the percentile register while the block is idle.
  task automatic write_percentile(logic [PCT_BITS-1:0] pct);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= pct;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pct_setting = pct;
  endtask

  task automatic check_result(logic [RESULT_W-1:0] beat);
    window_result_t         want;
    logic [RESULT_BITS-1:0] got_value;
    logic [COUNT_BITS-1:0]  got_count;
    got_value = beat[RESULT_BITS-1:0];
    got_count = beat[RESULT_BITS +: COUNT_BITS];
    results_checked++;
    if (expected_percentiles.size() == 0) begin
      report_mismatch("result with none pending, percentile_value", '0, got_value);
      return;
    end
    want = expected_percentiles.pop_front();
    if (got_value !== want.value) report_mismatch("percentile_value", want.value, got_value);
    if (got_count !== want.count) begin
      report_mismatch("window_count", RESULT_BITS'(want.count), RESULT_BITS'(got_count));
    end
    if (got_count == WINDOW_DEPTH) full_window_results++;
  endtask

  // Result side: check each accepted item and stall at random.
  initial begin : result_sink
    int unsigned stall_left;
    bit          sink_quiet;
    stall_left = 0;
    sink_quiet = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) check_result(m_tdata);
      if ($urandom_range(0, 99) == 0) sink_quiet = !sink_quiet;
      if (stall_left == 0 && !sink_quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      if (hold_active || stall_left != 0) begin
        m_tready <= 1'b0;
        if (stall_left != 0) stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Two long receiver holds while the sender keeps offering items.
  initial begin : long_hold
    while (results_checked < 150) @(posedge clk);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
    while (results_checked < 650) @(posedge clk);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending.",
               cycle_count, expected_percentiles.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stimulus: directed table, then random phases under several settings.
  initial begin : stimulus
    int unsigned             phase_pct [PHASES];
    int unsigned             phase_items [PHASES];
    window_result_t          want;
    logic [OP_BITS-1:0]      op;
    int unsigned             r;
    bit                      sender_burst;
    phase_pct   = '{5000, PCT_RESET, 0, FULL_SCALE, PCT_ABOVE, 0};
    phase_items = '{320, 130, 130, 130, 130, 110};
    phase_pct[PHASES-1] = $urandom_range(0, PCT_ABOVE);
    sender_burst = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      if (directed_rows[k].kind == ROW_PCT) begin
        write_percentile(directed_rows[k].data[PCT_BITS-1:0]);
      end else begin
        want.value = directed_rows[k].want_value;
        want.count = directed_rows[k].want_count;
        send_item(directed_rows[k].op, directed_rows[k].data, directed_rows[k].typed, want);
        idle_sender(pick_gap());
      end
    end

    // The first phase has no clears so the window fills and wraps.
    want = '0;
    for (int ph = 0; ph < PHASES; ph++) begin
      write_percentile(PCT_BITS'(phase_pct[ph]));
      for (int n = 0; n < phase_items[ph]; n++) begin
        r = $urandom_range(0, 199);
        if (ph != 0 && r < 2) op = OP_CLEAR;
        else if (r < 170) op = OP_RECORD;
        else if (r < 192) op = OP_QUERY;
        else op = OP_SPARE;
        send_item(op, pick_sample(), 1'b0, want);
        if ($urandom_range(0, 63) == 0) sender_burst = !sender_burst;
        idle_sender(sender_burst ? 0 : pick_gap());
      end
    end

    wait_drained();
    if (expected_percentiles.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived.", expected_percentiles.size());
    end
    $display("Sent %0d items (%0d clears) over %0d random phases; checked %0d results.",
             items_sent, clears_sent, PHASES, results_checked);
    $display("Results with a full window of %0d samples: %0d; mismatches: %0d.",
             WINDOW_DEPTH, full_window_results, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
+incdir+hdl
hdl/swpu_pkg.sv
hdl/swpu_ram.sv
hdl/swpu_cell.sv
hdl/swpu_or_tree.sv
hdl/sliding_window_percentile_unit.sv
tb/sliding_window_percentile_unit_test.sv
